// File: rtl/assert_macros.svh
// assertion helpers shared by the block's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: rtl/tsrb_pkg.sv
`default_nettype none

package tsrb_pkg;

   localparam int CFG_BITS       = 7;
   localparam int POOL_BITS      = 3;
   localparam int OP_BITS        = 3;
   localparam int SAMPLE_BITS    = 16;
   localparam int ID_BITS        = 8;
   localparam int STEP_BITS      = 6;
   localparam int CHAN_BITS      = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;
   // widest pooling group start and group size
   localparam int START_BITS     = CHAN_BITS + (2 ** POOL_BITS) - 1;
   localparam int GROUP_BITS     = 2 ** POOL_BITS;

   localparam int DEF_MAX_DEPTH  = 64;
   localparam int DEF_MAX_WIDTH  = 64;

   localparam logic [CFG_BITS-1:0]  RST_RING_DEPTH    = 7'd64;
   localparam logic [CFG_BITS-1:0]  RST_SLICE_WIDTH   = 7'd64;
   localparam logic [POOL_BITS-1:0] RST_POOL_SHIFT    = 3'd0;
   localparam logic [CFG_BITS-1:0]  RST_WINDOW_LENGTH = 7'd1;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE  = 3'd0,
      OP_RETAG  = 3'd1,
      OP_READ   = 3'd2,
      OP_VERIFY = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RING_DEPTH    = 2'd0,
      REG_SLICE_WIDTH   = 2'd1,
      REG_POOL_SHIFT    = 2'd2,
      REG_WINDOW_LENGTH = 2'd3
   } csr_reg_type;

   typedef struct packed {
      op_type                 op;
      logic [SAMPLE_BITS-1:0] sample;
      logic [ID_BITS-1:0]     model_id;
      logic [STEP_BITS-1:0]   step_index;
      logic [CHAN_BITS-1:0]   channel_index;
   } cmd_type;

   typedef struct packed {
      logic [CFG_BITS-1:0]  ring_depth;
      logic [CFG_BITS-1:0]  slice_width;
      logic [POOL_BITS-1:0] pool_shift;
      logic [CFG_BITS-1:0]  window_length;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/tsrb_ram.sv
`default_nettype none

module tsrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/tsrb_mod.sv
`default_nettype none

`include "assert_macros.svh"

// restoring remainder, one numerator bit per cycle
module tsrb_mod #(
   parameter int NW = 7,
   parameter int DW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic      [DW-1:0] rem
);

   localparam int CNT_BITS = $clog2(NW + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [NW-1:0]       num_ff;
   logic [DW-1:0]       den_ff;
   logic [DW-1:0]       rem_ff;
   logic [DW:0]         trial;

   assign trial = {rem_ff, num_ff[NW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= DW'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= DW'(trial);
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   `ASSERT_NEVER(mod_start_busy, clock, reset, start && busy_ff, "remainder restarted mid run")
   `ASSERT_PROP(mod_rem_bound, clock, reset, done_ff |-> (rem_ff < den_ff), "remainder not below divisor")

endmodule

`default_nettype wire

// File: rtl/tsrb_front.sv
`default_nettype none

`include "assert_macros.svh"

// accepts requests, drops unknown opcodes, queues the rest
module tsrb_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [tsrb_pkg::OP_BITS-1:0]         req_operation,
   input  wire logic signed [tsrb_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic [tsrb_pkg::ID_BITS-1:0]         req_model_id,
   input  wire logic [tsrb_pkg::STEP_BITS-1:0]       req_step_index,
   input  wire logic [tsrb_pkg::CHAN_BITS-1:0]       req_channel_index,
   input  wire logic                                 clearing,
   input  wire logic                                 cmd_pop,
   output logic                                      cmd_valid,
   output tsrb_pkg::cmd_type                         cmd
);

   localparam int QDEPTH = 2;
   localparam int QBITS  = $clog2(QDEPTH);
   localparam int CBITS  = $clog2(QDEPTH + 1);

   tsrb_pkg::cmd_type q_ff [QDEPTH];
   logic [QBITS-1:0]  wr_ff;
   logic [QBITS-1:0]  rd_ff;
   logic [CBITS-1:0]  cnt_ff;
   logic              push;
   tsrb_pkg::cmd_type new_cmd;

   assign busy = (cnt_ff == CBITS'(QDEPTH)) || clearing;
   assign push = start && !busy && (req_operation <= tsrb_pkg::OP_CLEAR);

   always_comb begin
      new_cmd.op            = tsrb_pkg::op_type'(req_operation);
      new_cmd.sample        = req_sample;
      new_cmd.model_id      = req_model_id;
      new_cmd.step_index    = req_step_index;
      new_cmd.channel_index = req_channel_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QBITS'(1);
         end
         if (cmd_pop) begin
            rd_ff <= rd_ff + QBITS'(1);
         end
         if (push && !cmd_pop) begin
            cnt_ff <= cnt_ff + CBITS'(1);
         end else if (cmd_pop && !push) begin
            cnt_ff <= cnt_ff - CBITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];

   `ASSERT_NEVER(front_pop_empty, clock, reset, cmd_pop && (cnt_ff == '0), "pop from empty queue")
   `ASSERT_PROP(front_head_known, clock, reset, cmd_valid |-> (cmd.op <= tsrb_pkg::OP_CLEAR), "unknown opcode queued")

endmodule

`default_nettype wire

// File: rtl/tsrb_back.sv
`default_nettype none

`include "assert_macros.svh"

// executes queued requests against the slice and tag stores
module tsrb_back #(
   parameter int MAX_DEPTH = tsrb_pkg::DEF_MAX_DEPTH,
   parameter int MAX_WIDTH = tsrb_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tsrb_pkg::cfg_type                 cfg,
   input  wire logic                              cmd_valid,
   input  wire tsrb_pkg::cmd_type                 cmd,
   output logic                                   cmd_pop,
   output logic                                   clearing,
   output logic                                   rsp_strobe,
   output logic signed [tsrb_pkg::SAMPLE_BITS-1:0] rsp_value,
   output logic                                   rsp_match
);

   localparam int CB    = tsrb_pkg::CFG_BITS;
   localparam int SB    = tsrb_pkg::SAMPLE_BITS;
   localparam int IB    = tsrb_pkg::ID_BITS;
   localparam int GB    = tsrb_pkg::GROUP_BITS;
   localparam int STB   = tsrb_pkg::START_BITS;
   localparam int DBITS = $clog2(MAX_DEPTH);
   localparam int PBITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int AW    = DBITS + PBITS;
   localparam int ED    = $clog2(MAX_DEPTH + 1);
   localparam int EW    = $clog2(MAX_WIDTH + 1);
   localparam int CD    = (CB > ED) ? CB : ED;
   localparam int CWW   = (CB > EW) ? CB : EW;
   localparam int NW    = (DBITS > CB) ? DBITS : CB;
   localparam int PW    = (STB > EW) ? STB : EW;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_PREP   = 7'b0000100,
      ST_NORM   = 7'b0001000,
      ST_SLICE  = 7'b0010000,
      ST_POOL   = 7'b0100000,
      ST_VERIFY = 7'b1000000
   } state_type;

   state_type         state_ff;
   tsrb_pkg::cmd_type cmd_ff;
   logic [DBITS-1:0]  wp_ff;
   logic [PBITS-1:0]  ec_ff;
   logic [AW-1:0]     clr_ff;
   logic [DBITS-1:0]  slice_ff;
   logic [PW-1:0]     p_ff;
   logic [GB-1:0]     left_ff;
   logic [CB-1:0]     t_ff;
   logic              pend_ff;
   logic              ok_ff;
   logic              any_ff;
   logic [SB-1:0]     best_ff;
   logic              rsp_strobe_ff;
   logic [SB-1:0]     rsp_value_ff;
   logic              rsp_match_ff;

   logic [CD-1:0]     rd_ext;
   logic [CWW-1:0]    sw_ext;
   logic [ED-1:0]     d;
   logic [EW-1:0]     w;
   logic [ED-1:0]     wp_ext;
   logic              norm_needed;
   logic [DBITS-1:0]  wp_inc;
   logic [DBITS-1:0]  retag_idx;
   logic [EW-1:0]     ec_ext;
   logic [EW-1:0]     pos_ext;
   logic [PBITS-1:0]  pos;
   logic              complete;
   logic [CB-1:0]     wl;
   logic [CB-1:0]     step_ext;
   logic [CB-1:0]     span;
   logic              read_skip;
   logic              mod_start;
   logic [NW-1:0]     mod_num;
   logic              mod_done;
   logic [ED-1:0]     mod_rem;
   logic [ED:0]       s_ext;
   logic [STB-1:0]    start_pos;
   logic              start_fits;
   logic [DBITS-1:0]  slice_inc;
   logic              pool_issue;
   logic              verify_issue;
   logic              run_now;
   logic [SB-1:0]     s_rdata;
   logic              s_we;
   logic [AW-1:0]     s_waddr;
   logic [SB-1:0]     s_wdata;
   logic [IB-1:0]     id_rdata;
   logic              id_we;
   logic [DBITS-1:0]  id_waddr;
   logic [IB-1:0]     id_wdata;

   // clamp the ring and slice sizes to what the stores hold
   assign rd_ext = CD'(cfg.ring_depth);
   assign sw_ext = CWW'(cfg.slice_width);
   assign d = (rd_ext == '0) ? ED'(1) :
              (rd_ext > CD'(MAX_DEPTH)) ? ED'(MAX_DEPTH) : ED'(rd_ext);
   assign w = (sw_ext == '0) ? EW'(1) :
              (sw_ext > CWW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(sw_ext);

   assign wp_ext      = ED'(wp_ff);
   assign norm_needed = (wp_ext >= d);
   assign wp_inc      = ((wp_ext + ED'(1)) == d) ? '0 : wp_ff + DBITS'(1);
   assign retag_idx   = (wp_ff == '0) ? DBITS'(d - ED'(1)) : wp_ff - DBITS'(1);

   assign ec_ext   = EW'(ec_ff);
   assign pos_ext  = (ec_ext < w) ? ec_ext : w - EW'(1);
   assign pos      = PBITS'(pos_ext);
   assign complete = ((pos_ext + EW'(1)) >= w);

   assign wl        = cfg.window_length;
   assign step_ext  = CB'(cmd_ff.step_index);
   assign span      = wl - step_ext;
   assign read_skip = (wl == '0) || (step_ext >= wl);

   // window slice is the head stepped back by the remainder, wrapped
   assign s_ext = (wp_ext >= mod_rem) ? {1'b0, wp_ext - mod_rem}
                                      : ({1'b0, wp_ext} + {1'b0, d} - {1'b0, mod_rem});

   assign start_pos  = STB'(cmd_ff.channel_index) << cfg.pool_shift;
   assign start_fits = (PW'(start_pos) < PW'(w));
   assign slice_inc  = ((ED'(slice_ff) + ED'(1)) == d) ? '0 : slice_ff + DBITS'(1);

   assign pool_issue   = (left_ff != '0) && (p_ff < PW'(w));
   assign verify_issue = (t_ff < wl);

   assign run_now = (state_ff == ST_PREP) && (cmd_ff.op != tsrb_pkg::OP_CLEAR) && !norm_needed;

   always_comb begin
      mod_start = 1'b0;
      mod_num   = NW'(wl);
      if ((state_ff == ST_PREP) && (cmd_ff.op != tsrb_pkg::OP_CLEAR)) begin
         priority if (norm_needed) begin
            mod_start = 1'b1;
            mod_num   = NW'(wp_ff);
         end else if (cmd_ff.op == tsrb_pkg::OP_READ) begin
            mod_start = !read_skip;
            mod_num   = NW'(span);
         end else if (cmd_ff.op == tsrb_pkg::OP_VERIFY) begin
            mod_start = (wl != '0);
            mod_num   = NW'(wl);
         end
      end
   end

   // store ports: the clearing pass owns the write side while it runs
   always_comb begin
      s_we     = clearing || (run_now && (cmd_ff.op == tsrb_pkg::OP_WRITE));
      s_waddr  = clearing ? clr_ff : {wp_ff, pos};
      s_wdata  = clearing ? '0 : cmd_ff.sample;
      id_we    = clearing || (run_now && (((cmd_ff.op == tsrb_pkg::OP_WRITE) && complete)
                                          || (cmd_ff.op == tsrb_pkg::OP_RETAG)));
      id_waddr = clearing ? clr_ff[AW-1 -: DBITS] :
                 (cmd_ff.op == tsrb_pkg::OP_RETAG) ? retag_idx : wp_ff;
      id_wdata = clearing ? '0 : cmd_ff.model_id;
   end

   assign clearing = (state_ff == ST_CLEAR);
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         wp_ff         <= '0;
         ec_ff         <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               priority if (cmd_ff.op == tsrb_pkg::OP_CLEAR) begin
                  state_ff <= ST_CLEAR;
                  clr_ff   <= '0;
                  wp_ff    <= '0;
                  ec_ff    <= '0;
               end else if (norm_needed) begin
                  state_ff <= ST_NORM;
               end else begin
                  unique case (cmd_ff.op)
                     tsrb_pkg::OP_WRITE: begin
                        if (complete) begin
                           wp_ff <= wp_inc;
                           ec_ff <= '0;
                        end else begin
                           ec_ff <= PBITS'(pos_ext + EW'(1));
                        end
                        state_ff <= ST_IDLE;
                     end
                     tsrb_pkg::OP_READ: begin
                        if (read_skip) begin
                           rsp_strobe_ff <= 1'b1;
                           state_ff      <= ST_IDLE;
                        end else begin
                           state_ff <= ST_SLICE;
                        end
                     end
                     tsrb_pkg::OP_VERIFY: begin
                        if (wl == '0) begin
                           rsp_strobe_ff <= 1'b1;
                           state_ff      <= ST_IDLE;
                        end else begin
                           state_ff <= ST_SLICE;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_NORM: begin
               if (mod_done) begin
                  wp_ff    <= DBITS'(mod_rem);
                  state_ff <= ST_PREP;
               end
            end
            ST_SLICE: begin
               if (mod_done) begin
                  pend_ff <= 1'b0;
                  if (cmd_ff.op == tsrb_pkg::OP_READ) begin
                     if (start_fits) begin
                        state_ff <= ST_POOL;
                     end else begin
                        rsp_strobe_ff <= 1'b1;
                        state_ff      <= ST_IDLE;
                     end
                  end else begin
                     state_ff <= ST_VERIFY;
                  end
               end
            end
            ST_POOL: begin
               pend_ff <= pool_issue;
               if (!pool_issue && !pend_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_VERIFY: begin
               pend_ff <= verify_issue;
               if (!verify_issue && !pend_ff) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ff <= cmd;
            end
         end
         ST_PREP: begin
            rsp_value_ff <= '0;
            rsp_match_ff <= 1'b0;
         end
         ST_SLICE: begin
            if (mod_done) begin
               slice_ff <= DBITS'(s_ext);
               p_ff     <= PW'(start_pos);
               left_ff  <= GB'(1) << cfg.pool_shift;
               t_ff     <= '0;
               ok_ff    <= 1'b1;
               any_ff   <= 1'b0;
               best_ff  <= '0;
            end
         end
         ST_POOL: begin
            if (pool_issue) begin
               p_ff    <= p_ff + PW'(1);
               left_ff <= left_ff - GB'(1);
            end
            if (pend_ff) begin
               any_ff <= 1'b1;
               if (!any_ff || ($signed(s_rdata) > $signed(best_ff))) begin
                  best_ff <= s_rdata;
               end
            end
            if (!pool_issue && !pend_ff) begin
               rsp_value_ff <= best_ff;
               rsp_match_ff <= 1'b0;
            end
         end
         ST_VERIFY: begin
            if (verify_issue) begin
               t_ff     <= t_ff + CB'(1);
               slice_ff <= slice_inc;
            end
            if (pend_ff && (id_rdata != cmd_ff.model_id)) begin
               ok_ff <= 1'b0;
            end
            if (!verify_issue && !pend_ff) begin
               rsp_value_ff <= '0;
               rsp_match_ff <= ok_ff;
            end
         end
         default: begin
         end
      endcase
   end

   tsrb_mod #(
      .NW (NW),
      .DW (ED)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .num   (mod_num),
      .den   (d),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   tsrb_ram #(
      .WIDTH (SB),
      .DEPTH (2 ** AW)
   ) u_sample_ram (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr ({slice_ff, p_ff[PBITS-1:0]}),
      .rdata (s_rdata)
   );

   tsrb_ram #(
      .WIDTH (IB),
      .DEPTH (MAX_DEPTH)
   ) u_id_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (id_waddr),
      .wdata (id_wdata),
      .raddr (slice_ff),
      .rdata (id_rdata)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_match  = rsp_match_ff;

   `ASSERT_PROP(back_single_strobe, clock, reset, rsp_strobe_ff |=> !rsp_strobe_ff, "result strobe held two cycles")
   `ASSERT_PROP(back_slice_in_ring, clock, reset, ((state_ff == ST_POOL) || (state_ff == ST_VERIFY)) |-> (ED'(slice_ff) < d), "window slice outside ring")

endmodule

`default_nettype wire

// File: rtl/tagged_slice_ring_buffer.sv
// tagged slice ring buffer: a ring of slices of q8.8 samples, one id tag per slice
//
// request channel: a request is taken at a rising edge with start high and busy low.
//   opcodes: write sample, retag newest slice, read pooled element, verify window
//   ids, clear. unknown opcodes are taken and dropped without effect.
// result channel: read and verify each give one result, shown for exactly one cycle
//   with rsp_strobe high; the receiver cannot stall, so the result is never held.
// csr channel: csr_valid with csr_index and csr_wdata writes one register; csr_ready
//   is always high. write only while no request is outstanding.
// requests pass through a two-entry queue; busy rises when it is full.
// execution unit: write and retag finish in the prep state; read walks the pooled
//   group, one sample store read per cycle; verify walks window_length tags, one
//   tag read per cycle. read and verify first run the bit-serial remainder unit,
//   one bit of max(7, log2 MAX_DEPTH) per cycle.
//   the first request after ring_depth shrinks below the head adds one extra pass.
// reset and clear run a clearing pass that zeroes every entry of the sample and
//   tag stores, busy high meanwhile
`default_nettype none

module tagged_slice_ring_buffer #(
   parameter int MAX_DEPTH = tsrb_pkg::DEF_MAX_DEPTH,
   parameter int MAX_WIDTH = tsrb_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [tsrb_pkg::OP_BITS-1:0]            req_operation,
   input  wire logic signed [tsrb_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic [tsrb_pkg::ID_BITS-1:0]            req_model_id,
   input  wire logic [tsrb_pkg::STEP_BITS-1:0]          req_step_index,
   input  wire logic [tsrb_pkg::CHAN_BITS-1:0]          req_channel_index,
   // result channel
   output logic                                         rsp_strobe,
   output logic signed [tsrb_pkg::SAMPLE_BITS-1:0]      rsp_value,
   output logic                                         rsp_match,
   // register writes
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [tsrb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [tsrb_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   tsrb_pkg::cfg_type cfg_ff;
   tsrb_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   logic              clearing;

   // registers are always writable, the block is idle by contract
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_depth    <= tsrb_pkg::RST_RING_DEPTH;
         cfg_ff.slice_width   <= tsrb_pkg::RST_SLICE_WIDTH;
         cfg_ff.pool_shift    <= tsrb_pkg::RST_POOL_SHIFT;
         cfg_ff.window_length <= tsrb_pkg::RST_WINDOW_LENGTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tsrb_pkg::REG_RING_DEPTH: begin
               cfg_ff.ring_depth <= csr_wdata[tsrb_pkg::CFG_BITS-1:0];
            end
            tsrb_pkg::REG_SLICE_WIDTH: begin
               cfg_ff.slice_width <= csr_wdata[tsrb_pkg::CFG_BITS-1:0];
            end
            tsrb_pkg::REG_POOL_SHIFT: begin
               cfg_ff.pool_shift <= csr_wdata[tsrb_pkg::POOL_BITS-1:0];
            end
            tsrb_pkg::REG_WINDOW_LENGTH: begin
               cfg_ff.window_length <= csr_wdata[tsrb_pkg::CFG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // front end: takes requests, drops unknown opcodes, queues the rest
   tsrb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_sample        (req_sample),
      .req_model_id      (req_model_id),
      .req_step_index    (req_step_index),
      .req_channel_index (req_channel_index),
      .clearing          (clearing),
      .cmd_pop           (cmd_pop),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd)
   );

   // back end: stores, remainder unit, pooling and tag walk
   tsrb_back #(
      .MAX_DEPTH (MAX_DEPTH),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value),
      .rsp_match  (rsp_match)
   );

endmodule

`default_nettype wire
